### rtl/cfzp_pkg.sv
// Shared types and constants for the centered zero-padded FIR core.
package cfzp_pkg;

    localparam int OUT_BITS       = 36;
    localparam int OUT_DATA_BITS  = 40;
    localparam int TAP_COUNT_BITS = 5;
    localparam int COEF_IDX_BITS  = 4;
    localparam int CFG_ADDR_BITS  = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_INDEX = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_VALUE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MAC,
        ST_WAIT,
        ST_PUSH
    } state_t;

endpackage

### rtl/cfzp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cfzp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/centered_fir_zero_pad_core.sv
// Centered FIR correlation with zero padding at both ends of each sequence.
//
// Samples arrive as beats on the s_ channel, with s_tlast on the final
// sample of a sequence. Filtered results leave as beats on the m_ channel,
// with m_tlast on the last result of a sequence. With T taps in use and
// edge E = T/2, the first E samples of a sequence give no result; the
// sample carrying s_tlast is followed by E zero flush steps, so a
// sequence gives one result per sample. Samples and coefficients live
// in two RAMs with a registered read. One multiply-accumulate runs per
// tap per cycle; a step with a result goes through the MAC, wait and
// push states, a step without one goes straight to push, and an input
// beat is taken once the previous one has finished all of its steps.
// A finished result waits in the output register while the core moves on;
// when the receiver stalls and a second result is ready, the core holds
// until the output register is taken.
// The configuration port writes tap_count, coef_index and coef_value;
// writing coef_value stores into the tap selected by coef_index.
// Reset sets one tap, zero coefficients and an empty delay line; no
// clearing pass is needed since a fill count masks stale samples.
module centered_fir_zero_pad_core
    import cfzp_pkg::*;
#(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // s_tdata: sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                   s_tlast,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // m_tdata: filtered
    output logic [OUT_DATA_BITS-1:0]               m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]               cfg_addr,
    input  logic [COEF_BITS-1:0]                   cfg_wdata
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int RD = 2 ** AW;
    localparam int TW = $clog2(MAX_TAPS + 1) + 1;
    localparam int PW = SAMPLE_BITS + COEF_BITS;

    state_t state_reg, state_next;

    logic [TAP_COUNT_BITS-1:0] tap_count_reg;
    logic [COEF_IDX_BITS-1:0]  coef_index_reg;
    logic [MAX_TAPS-1:0]       coef_vld_reg;

    logic [TW-1:0] taps_cur;
    logic [TW-1:0] t_reg, e_reg, j_reg, warm_reg, fill_reg, flush_reg;
    logic [AW-1:0] wp_reg;
    logic          last_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;

    logic [TW-1:0] hist_idx;
    logic          hist_zero_reg, hist_ok_reg, coef_ok_reg;
    logic          rd_vld_reg, prod_vld_reg;
    logic signed [SAMPLE_BITS-1:0] hist_val;
    logic signed [COEF_BITS-1:0]   coef_val;
    logic signed [PW-1:0]          prod_reg;
    logic signed [OUT_BITS-1:0]    acc_reg;
    logic signed [OUT_BITS-1:0]    out_reg;
    logic                          out_last_reg;
    logic                          m_tvalid_reg;

    logic [SAMPLE_BITS-1:0] dl_q;
    logic [COEF_BITS-1:0]   cf_q;
    logic [AW-1:0]          dl_raddr;
    logic                   coef_we;

    logic in_acc, out_free, pipe_empty, due, emit, issue, push, mac_done;

    assign in_acc     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign due        = warm_reg >= e_reg;
    assign mac_done   = j_reg == (t_reg - TW'(1));
    assign hist_idx   = (e_reg << 1) - j_reg;
    assign dl_raddr   = wp_reg - AW'(hist_idx);
    assign coef_we    = cfg_wr_en && (cfg_addr == REG_COEF_VALUE)
                        && (32'(coef_index_reg) < MAX_TAPS);

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_cur = TW'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_cur = TW'(MAX_TAPS);
        end else begin
            taps_cur = TW'(tap_count_reg);
        end
    end

    cfzp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RD)) u_delay_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (x_reg),
        .raddr (dl_raddr),
        .rdata (dl_q)
    );

    cfzp_ram #(.WIDTH(COEF_BITS), .DEPTH(RD)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (AW'(coef_index_reg)),
        .wdata (cfg_wdata),
        .raddr (AW'(j_reg)),
        .rdata (cf_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = due ? ST_MAC : ST_PUSH;
            end
            ST_MAC: begin
                if (mac_done) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (pipe_empty && out_free) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (last_reg && (flush_reg != '0)) begin
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        issue    = (state_reg == ST_MAC);
        emit     = (state_reg == ST_WAIT) && pipe_empty && out_free;
        push     = (state_reg == ST_PUSH);
    end

    assign hist_val = hist_zero_reg ? x_reg
                    : (hist_ok_reg ? $signed(dl_q) : '0);
    assign coef_val = coef_ok_reg ? $signed(cf_q) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tap_count_reg  <= TAP_COUNT_BITS'(1);
            coef_index_reg <= '0;
            coef_vld_reg   <= '0;
            warm_reg       <= '0;
            fill_reg       <= '0;
            wp_reg         <= '0;
            rd_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;

            if (cfg_wr_en && (cfg_addr == REG_TAP_COUNT)) begin
                tap_count_reg <= cfg_wdata[TAP_COUNT_BITS-1:0];
            end
            if (cfg_wr_en && (cfg_addr == REG_COEF_INDEX)) begin
                coef_index_reg <= cfg_wdata[COEF_IDX_BITS-1:0];
            end
            if (coef_we) begin
                coef_vld_reg[coef_index_reg] <= 1'b1;
            end

            if ((state_reg == ST_STEP) && !due) begin
                warm_reg <= warm_reg + TW'(1);
            end

            if (push) begin
                wp_reg <= wp_reg + AW'(1);
                if (last_reg && (flush_reg == '0)) begin
                    fill_reg <= '0;
                    warm_reg <= '0;
                end else if (32'(fill_reg) < MAX_TAPS) begin
                    fill_reg <= fill_reg + TW'(1);
                end
            end

            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            x_reg     <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            last_reg  <= s_tlast;
            t_reg     <= taps_cur;
            e_reg     <= taps_cur >> 1;
            flush_reg <= taps_cur >> 1;
        end
        if (push && last_reg && (flush_reg != '0)) begin
            x_reg     <= '0;
            flush_reg <= flush_reg - TW'(1);
        end

        if (state_reg == ST_STEP) begin
            j_reg   <= '0;
            acc_reg <= '0;
        end else begin
            if (issue) begin
                j_reg <= j_reg + TW'(1);
            end
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + OUT_BITS'(prod_reg);
            end
        end

        hist_zero_reg <= (hist_idx == '0);
        hist_ok_reg   <= (hist_idx != '0) && ((hist_idx - TW'(1)) < fill_reg);
        coef_ok_reg   <= coef_vld_reg[AW'(j_reg)];
        prod_reg      <= PW'(hist_val) * PW'(coef_val);

        if (emit) begin
            out_reg      <= acc_reg;
            out_last_reg <= last_reg && (flush_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - OUT_BITS){1'b0}}, out_reg};
    assign m_tlast  = out_last_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the centered zero-padded FIR core.
`timescale 1ns / 1ps

module testbench;
    import cfzp_pkg::*;

    localparam int TAP_LIMIT    = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_BITS-1:0] filtered;
        logic                final_res;
    } filt_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic [15:0]              s_tdata;
    logic                     s_tlast;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [15:0]              cfg_wdata;

    logic signed [15:0] sample_line [TAP_LIMIT];
    logic signed [15:0] coef_mem [TAP_LIMIT];
    int unsigned        fill_count;
    logic [4:0]         cfg_taps;
    logic [3:0]         cfg_coef_sel;

    filt_result_t pending_results[$];
    int unsigned  mismatches = 0;
    int unsigned  idle_run = 0;
    bit           no_idle = 1'b0;

    centered_fir_zero_pad_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned active_taps();
        int unsigned t = cfg_taps;
        if (t < 1) t = 1;
        if (t > TAP_LIMIT) t = TAP_LIMIT;
        return t;
    endfunction

    function automatic bit shift_sample(input logic signed [15:0] x,
                                        output logic [OUT_BITS-1:0] sum);
        int unsigned        t;
        int unsigned        e;
        int unsigned        k;
        longint             acc;
        logic signed [15:0] s;
        bit                 due;
        t = active_taps();
        e = t / 2;
        due = 1'b0;
        sum = '0;
        if (fill_count >= e) begin
            acc = 0;
            for (int j = 0; j < t; j++) begin
                k = 2 * e - j;
                s = (k == 0) ? x : sample_line[k-1];
                acc += longint'(s) * longint'(coef_mem[j]);
            end
            sum = acc[OUT_BITS-1:0];
            due = 1'b1;
        end else begin
            fill_count++;
        end
        for (int i = TAP_LIMIT - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
        sample_line[0] = x;
        return due;
    endfunction

    function automatic void predict_sample(logic signed [15:0] x, bit last);
        filt_result_t        batch[$];
        logic [OUT_BITS-1:0] sum;
        int unsigned         e;
        if (shift_sample(x, sum)) batch.push_back('{filtered: sum, final_res: 1'b0});
        if (last) begin
            e = active_taps() / 2;
            for (int i = 0; i < e; i++) begin
                if (shift_sample(16'sd0, sum))
                    batch.push_back('{filtered: sum, final_res: 1'b0});
            end
            if (batch.size() > 0) batch[batch.size()-1].final_res = 1'b1;
            foreach (sample_line[i]) sample_line[i] = '0;
            fill_count = 0;
        end
        foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_sample(logic signed [15:0] x, bit last);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= x;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sample(x, last);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            REG_TAP_COUNT:  cfg_taps = data[4:0];
            REG_COEF_INDEX: cfg_coef_sel = data[3:0];
            REG_COEF_VALUE: coef_mem[cfg_coef_sel] = data;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_coef(logic [3:0] idx, logic [15:0] value);
        write_reg(REG_COEF_INDEX, {12'd0, idx});
        write_reg(REG_COEF_VALUE, value);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
    endtask

    task automatic test_full_scale();
        settle();
        write_reg(REG_TAP_COUNT, 16'd16);
        for (int j = 0; j < TAP_LIMIT; j++) set_coef(4'(j), 16'h8000);
        for (int i = 0; i < 6; i++) send_sample(16'sh8000, i == 5);
        settle();
        for (int j = 0; j < TAP_LIMIT; j++) set_coef(4'(j), 16'h7FFF);
        for (int i = 0; i < 4; i++) send_sample(16'sh8000, i == 3);
    endtask

    task automatic test_tap_count_limits();
        settle();
        write_reg(REG_TAP_COUNT, 16'd0);
        send_sample(16'sh1234, 1'b0);
        send_sample(16'sh8000, 1'b1);
        settle();
        write_reg(REG_TAP_COUNT, 16'hFFFF);
        send_sample(16'sh7FFF, 1'b1);
    endtask

    task automatic test_taps_change_in_sequence();
        settle();
        write_reg(REG_TAP_COUNT, 16'd4);
        for (int i = 0; i < 3; i++) send_sample(pick_sample(), 1'b0);
        settle();
        write_reg(REG_TAP_COUNT, 16'd9);
        for (int i = 0; i < 3; i++) send_sample(pick_sample(), i == 2);
    endtask

    task automatic test_register_decode();
        settle();
        set_coef(4'd15, 16'h5A5A);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_TAP_COUNT, 16'd16);
        send_sample(16'sh4321, 1'b0);
        send_sample(16'shBCDE, 1'b1);
    endtask

    task automatic test_random_traffic(int unsigned item_goal);
        int unsigned sent;
        int unsigned seqs;
        int unsigned len;
        bit          open_seq;
        sent = 0;
        while (sent < item_goal) begin
            settle();
            no_idle = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0: write_reg(REG_TAP_COUNT, 16'd0);
                1: write_reg(REG_TAP_COUNT, 16'd31);
                2: write_reg(REG_TAP_COUNT, 16'd16);
                3: write_reg(REG_TAP_COUNT, 16'd1);
                default: write_reg(REG_TAP_COUNT, 16'($urandom));
            endcase
            repeat ($urandom_range(0, 6)) set_coef(4'($urandom), 16'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                for (int j = 0; j < TAP_LIMIT; j++)
                    set_coef(4'(j), $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
            end
            if ($urandom_range(0, 9) == 0) write_reg(REG_COEF_INDEX, 16'($urandom));
            if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, 16'($urandom));
            seqs = $urandom_range(1, 4);
            for (int q = 0; q < seqs; q++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
                open_seq = (q == seqs - 1) && ($urandom_range(0, 7) == 0);
                for (int i = 0; i < len; i++) begin
                    send_sample(pick_sample(), !open_seq && i == len - 1);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin : check_results
        filt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, data %0h",
                                          m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[OUT_BITS-1:0] !== want.filtered)
                    report_mismatch($sformatf("filtered %0d, expected %0d",
                                              $signed(m_tdata[OUT_BITS-1:0]),
                                              $signed(want.filtered)));
                if (m_tlast !== want.final_res)
                    report_mismatch($sformatf("tlast %b, expected %b",
                                              m_tlast, want.final_res));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tvalid  = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        foreach (sample_line[i]) sample_line[i] = '0;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        fill_count   = 0;
        cfg_taps     = 5'd1;
        cfg_coef_sel = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_full_scale();
        test_tap_count_limits();
        test_taps_change_in_sequence();
        test_register_decode();
        test_random_traffic(437);

        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
